// ===== rtl/vlrc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vehicle lighting relay controller - shared package
// Switch bit positions, register indexes, timer widths and the word types
// passed between the controller modules.
// ----------------------------------------------------------------------------
package vlrc_pkg;

    // Combined switch word: body switches in bits 0..6, light switches 7..14
    localparam int unsigned SW_W = 15;

    localparam int unsigned SW_DOOR     = 0;
    localparam int unsigned SW_INTERIOR = 1;
    localparam int unsigned SW_IGNITION = 2;
    localparam int unsigned SW_START    = 3;
    localparam int unsigned SW_BRAKE    = 4;
    localparam int unsigned SW_REVERSE  = 5;
    localparam int unsigned SW_UNLOCK   = 6;
    localparam int unsigned SW_HAZARD   = 7;
    localparam int unsigned SW_LEFT     = 8;
    localparam int unsigned SW_RIGHT    = 9;
    localparam int unsigned SW_MARKERS  = 10;
    localparam int unsigned SW_HEAD     = 11;
    localparam int unsigned SW_HIGH     = 12;
    localparam int unsigned SW_TOGGLE   = 13;
    localparam int unsigned SW_FOG      = 14;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_TURN_PERIOD  = 3'd0;
    localparam t_cfg_idx CFG_BRAKE_PERIOD = 3'd1;
    localparam t_cfg_idx CFG_BRAKE_COUNT  = 3'd2;
    localparam t_cfg_idx CFG_INTERIOR_SEC = 3'd3;
    localparam t_cfg_idx CFG_PATH_SEC     = 3'd4;

    // Timer widths: flash half-period up to 255 x 100 ms, hold up to 255 s
    typedef logic [14:0] t_flash_ms;
    typedef logic [17:0] t_hold_ms;
    localparam t_flash_ms FLASH_UNIT_MS = 15'd100;
    localparam t_hold_ms  MS_PER_SEC    = 18'd1000;

    typedef struct packed {
        logic [7:0] turn_period;
        logic [7:0] brake_period;
        logic [7:0] brake_count;
        logic [7:0] interior_sec;
        logic [7:0] path_sec;
    } t_cfg;

    typedef struct packed {
        logic interior_light;
        logic left_turn;
        logic right_turn;
        logic marker_lamps;
        logic lights_down;
        logic lights_up;
        logic head_power;
        logic high_beam;
        logic low_beam;
        logic fog_lamps;
        logic brake_lamps;
        logic reverse_lamps;
    } t_relays;

endpackage

// ===== rtl/vehicle_lighting_relay_controller_core.sv =====
// ----------------------------------------------------------------------------
// Vehicle lighting relay controller - top level
// Input register, lighting logic, configuration registers and result
// register for the relay word.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall) carries one word per item: i_mode = 1
//   is a 1 ms tick that advances the timers and gives no result; i_mode = 0
//   is a switch scan that gives one relay word on the output channel
//   (o_valid / i_stall).
//   A word is taken into the input register and processed there; a scan
//   then moves its relay word into the result register, which drives
//   o_valid. One word per cycle is sustained in both modes while o_stall
//   stays low.
//   The result register holds the relay word while i_stall is high; the
//   input register keeps taking a word and only raises o_stall when a scan
//   sits in it while the result register is full and stalled. Ticks never
//   wait on the output side.
//   Configuration writes (i_cfg_valid, always ready) go to five 8-bit
//   registers by index; unused indexes are ignored. Write them only while
//   the block is idle.
//   Reset (i_rst_n low, synchronous) empties both registers, stops all
//   timers, clears the switch history and restores register defaults.
// ----------------------------------------------------------------------------
module vehicle_lighting_relay_controller_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // item input
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic                       i_mode,
    input  logic [6:0]                 i_body_switches,
    input  logic [7:0]                 i_light_switches,
    // configuration write
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  vlrc_pkg::t_cfg_idx         i_cfg_index,
    input  logic [7:0]                 i_cfg_data,
    // relay output
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_interior_light,
    output logic                       o_left_turn,
    output logic                       o_right_turn,
    output logic                       o_marker_lamps,
    output logic                       o_lights_down,
    output logic                       o_lights_up,
    output logic                       o_head_power,
    output logic                       o_high_beam,
    output logic                       o_low_beam,
    output logic                       o_fog_lamps,
    output logic                       o_brake_lamps,
    output logic                       o_reverse_lamps
);

    logic                          r_in_valid, n_in_valid;
    logic                          r_in_mode;
    logic [vlrc_pkg::SW_W-1:0]     r_in_sw;
    logic                          r_out_valid, n_out_valid;
    vlrc_pkg::t_relays             r_out;
    vlrc_pkg::t_relays             relays;
    vlrc_pkg::t_cfg                cfg;
    logic                          out_free;
    logic                          go;
    logic                          in_take;

    // Flow control
    assign out_free    = !r_out_valid || !i_stall;
    assign go          = r_in_valid && (r_in_mode || out_free);
    assign o_stall     = r_in_valid && !go;
    assign in_take     = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_take) begin
            n_in_valid = 1'b1;
        end else if (go) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (go && !r_in_mode) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_mode <= i_mode;
            r_in_sw   <= {i_light_switches, i_body_switches};
        end
    end

    vlrc_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (cfg)
    );

    vlrc_logic u_logic (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_go     (go),
        .i_mode   (r_in_mode),
        .i_sw     (r_in_sw),
        .i_cfg    (cfg),
        .o_relays (relays)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (go && !r_in_mode) begin
            r_out <= relays;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_interior_light = r_out.interior_light;
    assign o_left_turn      = r_out.left_turn;
    assign o_right_turn     = r_out.right_turn;
    assign o_marker_lamps   = r_out.marker_lamps;
    assign o_lights_down    = r_out.lights_down;
    assign o_lights_up      = r_out.lights_up;
    assign o_head_power     = r_out.head_power;
    assign o_high_beam      = r_out.high_beam;
    assign o_low_beam       = r_out.low_beam;
    assign o_fog_lamps      = r_out.fog_lamps;
    assign o_brake_lamps    = r_out.brake_lamps;
    assign o_reverse_lamps  = r_out.reverse_lamps;

    // Checks
    a_tick_never_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && r_in_mode) |-> !o_stall)
        else $error("tick word held in input register");

    a_scan_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !r_in_mode && out_free) |=> o_valid)
        else $error("processed scan did not produce a relay word");

    a_stall_keeps_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> (r_in_valid && !r_in_mode && $stable(r_in_sw)))
        else $error("stalled scan word lost from input register");

endmodule

// ===== rtl/vlrc_cfg.sv =====
// ----------------------------------------------------------------------------
// Vehicle lighting relay controller - configuration registers
// Five 8-bit registers written through a valid/ready port; writes to an
// index beyond the list are dropped.
// ----------------------------------------------------------------------------
module vlrc_cfg (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_wr,
    input  vlrc_pkg::t_cfg_idx     i_index,
    input  logic [7:0]             i_data,
    output vlrc_pkg::t_cfg         o_cfg
);

    vlrc_pkg::t_cfg r_cfg;
    vlrc_pkg::t_cfg n_cfg;

    // Register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_wr) begin
            unique case (i_index)
                vlrc_pkg::CFG_TURN_PERIOD:  n_cfg.turn_period  = i_data;
                vlrc_pkg::CFG_BRAKE_PERIOD: n_cfg.brake_period = i_data;
                vlrc_pkg::CFG_BRAKE_COUNT:  n_cfg.brake_count  = i_data;
                vlrc_pkg::CFG_INTERIOR_SEC: n_cfg.interior_sec = i_data;
                vlrc_pkg::CFG_PATH_SEC:     n_cfg.path_sec     = i_data;
                default:                    n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.turn_period  <= 8'd5;
            r_cfg.brake_period <= 8'd1;
            r_cfg.brake_count  <= 8'd3;
            r_cfg.interior_sec <= 8'd30;
            r_cfg.path_sec     <= 8'd30;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== rtl/vlrc_logic.sv =====
// ----------------------------------------------------------------------------
// Vehicle lighting relay controller - lighting state and relay logic
// Holds the flasher and hold timers and the switch history. On a tick word
// the timers advance; on a scan word edges are found, timers are restarted
// or loaded and the relay word is formed combinationally; the state is registered.
// ----------------------------------------------------------------------------
module vlrc_logic (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_go,
    input  logic                          i_mode,
    input  logic [vlrc_pkg::SW_W-1:0]     i_sw,
    input  vlrc_pkg::t_cfg                i_cfg,
    output vlrc_pkg::t_relays             o_relays
);

    logic [vlrc_pkg::SW_W-1:0] r_prev, n_prev;
    logic                      r_turn_phase, n_turn_phase;
    vlrc_pkg::t_flash_ms       r_turn_rem, n_turn_rem;
    vlrc_pkg::t_flash_ms       r_turn_int, n_turn_int;
    logic                      r_brake_phase, n_brake_phase;
    vlrc_pkg::t_flash_ms       r_brake_rem, n_brake_rem;
    vlrc_pkg::t_flash_ms       r_brake_int, n_brake_int;
    logic [7:0]                r_brake_left, n_brake_left;
    vlrc_pkg::t_hold_ms        r_int_rem, n_int_rem;
    vlrc_pkg::t_hold_ms        r_path_rem, n_path_rem;
    logic                      r_hb, n_hb;
    logic                      r_ign_off, n_ign_off;

    logic [vlrc_pkg::SW_W-1:0] sw;
    logic [vlrc_pkg::SW_W-1:0] chg;
    logic                      ign;
    logic                      turn_restart;
    logic                      brake_restart;
    logic                      start_path;
    vlrc_pkg::t_flash_ms       turn_dec;
    vlrc_pkg::t_flash_ms       brake_dec;
    vlrc_pkg::t_flash_ms       turn_load;
    vlrc_pkg::t_flash_ms       brake_load;
    vlrc_pkg::t_hold_ms        int_load;
    vlrc_pkg::t_hold_ms        path_load;
    vlrc_pkg::t_relays         rel;

    assign sw  = i_sw;
    assign chg = i_sw ^ r_prev;
    assign ign = sw[vlrc_pkg::SW_IGNITION];

    // Reload values from the registers
    assign turn_load  = vlrc_pkg::t_flash_ms'(i_cfg.turn_period) * vlrc_pkg::FLASH_UNIT_MS;
    assign brake_load = vlrc_pkg::t_flash_ms'(i_cfg.brake_period) * vlrc_pkg::FLASH_UNIT_MS;
    assign int_load   = vlrc_pkg::t_hold_ms'(i_cfg.interior_sec) * vlrc_pkg::MS_PER_SEC;
    assign path_load  = vlrc_pkg::t_hold_ms'(i_cfg.path_sec) * vlrc_pkg::MS_PER_SEC;

    assign turn_dec  = r_turn_rem - 15'd1;
    assign brake_dec = r_brake_rem - 15'd1;

    // Flasher restarts on a scan
    always_comb begin
        if (sw[vlrc_pkg::SW_HAZARD]) begin
            turn_restart = chg[vlrc_pkg::SW_HAZARD];
        end else begin
            turn_restart = ign &&
                ((sw[vlrc_pkg::SW_LEFT] && chg[vlrc_pkg::SW_LEFT]) ||
                 (sw[vlrc_pkg::SW_RIGHT] && chg[vlrc_pkg::SW_RIGHT]));
        end
    end
    assign brake_restart = sw[vlrc_pkg::SW_BRAKE] && chg[vlrc_pkg::SW_BRAKE];

    // Next state and relay word
    always_comb begin
        n_prev        = r_prev;
        n_turn_phase  = r_turn_phase;
        n_turn_rem    = r_turn_rem;
        n_turn_int    = r_turn_int;
        n_brake_phase = r_brake_phase;
        n_brake_rem   = r_brake_rem;
        n_brake_int   = r_brake_int;
        n_brake_left  = r_brake_left;
        n_int_rem     = r_int_rem;
        n_path_rem    = r_path_rem;
        n_hb          = r_hb;
        n_ign_off     = r_ign_off;
        start_path    = 1'b0;
        rel           = '0;

        if (i_go && i_mode) begin
            // millisecond tick
            if (r_turn_rem != '0) begin
                if (turn_dec == '0) begin
                    n_turn_rem   = r_turn_int;
                    n_turn_phase = !r_turn_phase;
                end else begin
                    n_turn_rem = turn_dec;
                end
            end
            if (r_brake_rem != '0) begin
                if (brake_dec == '0) begin
                    n_brake_rem = r_brake_int;
                    if (r_brake_phase && r_brake_left != 8'd0) begin
                        n_brake_phase = 1'b0;
                        n_brake_left  = r_brake_left - 8'd1;
                    end else begin
                        n_brake_phase = 1'b1;
                        if (r_brake_left == 8'd0) begin
                            n_brake_rem = '0;
                        end
                    end
                end else begin
                    n_brake_rem = brake_dec;
                end
            end
            if (r_int_rem != '0) begin
                n_int_rem = r_int_rem - 18'd1;
            end
            if (r_path_rem != '0) begin
                n_path_rem = r_path_rem - 18'd1;
            end
        end else if (i_go) begin
            // switch scan
            n_prev = sw;

            // interior light, loaded when the door closes
            if (!sw[vlrc_pkg::SW_DOOR] && chg[vlrc_pkg::SW_DOOR]) begin
                n_int_rem = int_load;
            end
            rel.interior_light = sw[vlrc_pkg::SW_DOOR] || sw[vlrc_pkg::SW_INTERIOR] ||
                                 (!ign && n_int_rem != '0);

            // turn, hazard and parking lamps
            if (turn_restart) begin
                n_turn_phase = 1'b1;
                n_turn_int   = turn_load;
                n_turn_rem   = turn_load;
            end
            if (sw[vlrc_pkg::SW_HAZARD]) begin
                rel.left_turn  = n_turn_phase;
                rel.right_turn = n_turn_phase;
            end else if (!ign) begin
                rel.left_turn  = sw[vlrc_pkg::SW_LEFT];
                rel.right_turn = sw[vlrc_pkg::SW_RIGHT];
            end else begin
                // left sees the phase before a right-hand restart relights it
                rel.left_turn  = sw[vlrc_pkg::SW_LEFT] &&
                                 (chg[vlrc_pkg::SW_LEFT] || r_turn_phase);
                rel.right_turn = sw[vlrc_pkg::SW_RIGHT] && n_turn_phase;
            end

            // headlights
            rel.lights_down = !sw[vlrc_pkg::SW_MARKERS] && !sw[vlrc_pkg::SW_HEAD] &&
                              !sw[vlrc_pkg::SW_HIGH];
            if (ign) begin
                if (chg[vlrc_pkg::SW_IGNITION]) begin
                    n_hb = 1'b0;
                end
                if (sw[vlrc_pkg::SW_TOGGLE] && chg[vlrc_pkg::SW_TOGGLE]) begin
                    n_hb = !n_hb;
                end
                if (sw[vlrc_pkg::SW_HEAD] || sw[vlrc_pkg::SW_HIGH]) begin
                    rel.head_power  = 1'b1;
                    rel.lights_up   = 1'b1;
                    rel.lights_down = 1'b0;
                    if (!sw[vlrc_pkg::SW_START]) begin
                        rel.high_beam = sw[vlrc_pkg::SW_HIGH] || n_hb;
                        rel.low_beam  = !(sw[vlrc_pkg::SW_HIGH] || n_hb);
                    end
                end
                rel.fog_lamps = sw[vlrc_pkg::SW_FOG];
            end

            // brake and reverse
            if (brake_restart) begin
                n_brake_phase = 1'b1;
                n_brake_int   = brake_load;
                n_brake_rem   = brake_load;
                n_brake_left  = i_cfg.brake_count;
            end
            rel.brake_lamps   = sw[vlrc_pkg::SW_BRAKE] && n_brake_phase;
            rel.reverse_lamps = sw[vlrc_pkg::SW_REVERSE];

            // path lighting after the ignition goes off or the unlock switch changes
            if (!ign && chg[vlrc_pkg::SW_IGNITION]) begin
                if (sw[vlrc_pkg::SW_DOOR]) begin
                    start_path = 1'b1;
                end else begin
                    n_ign_off = 1'b1;
                end
            end
            if (sw[vlrc_pkg::SW_DOOR] && chg[vlrc_pkg::SW_DOOR] && n_ign_off) begin
                start_path = 1'b1;
            end
            if (!ign && chg[vlrc_pkg::SW_UNLOCK]) begin
                start_path = 1'b1;
            end
            if (start_path) begin
                n_ign_off  = 1'b0;
                n_path_rem = path_load;
            end
            rel.marker_lamps = sw[vlrc_pkg::SW_MARKERS] || (n_path_rem != '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev        <= '0;
            r_turn_phase  <= 1'b1;
            r_turn_rem    <= '0;
            r_turn_int    <= '0;
            r_brake_phase <= 1'b1;
            r_brake_rem   <= '0;
            r_brake_int   <= '0;
            r_brake_left  <= 8'd0;
            r_int_rem     <= '0;
            r_path_rem    <= '0;
            r_hb          <= 1'b0;
            r_ign_off     <= 1'b0;
        end else begin
            r_prev        <= n_prev;
            r_turn_phase  <= n_turn_phase;
            r_turn_rem    <= n_turn_rem;
            r_turn_int    <= n_turn_int;
            r_brake_phase <= n_brake_phase;
            r_brake_rem   <= n_brake_rem;
            r_brake_int   <= n_brake_int;
            r_brake_left  <= n_brake_left;
            r_int_rem     <= n_int_rem;
            r_path_rem    <= n_path_rem;
            r_hb          <= n_hb;
            r_ign_off     <= n_ign_off;
        end
    end

    assign o_relays = rel;

endmodule
